@@ rtl/dpat_pkg.sv @@
`timescale 1ns / 1ps

package dpat_pkg;

  // Table geometry and field widths
  localparam int TableEntriesDef = 16;
  localparam int ReportMax       = 16;
  localparam int IdxOutW         = 4;
  localparam int IdCharW         = 8;
  localparam int DevIdW          = 9;
  localparam int CountW          = 16;
  localparam int TtlW            = 4;
  localparam int RepCntW         = 5;
  localparam int OutDataW        = 32;

  localparam logic [TtlW-1:0]    TtlResetVal = 4'd5;
  localparam logic [DevIdW-1:0]  IdOffset    = 9'h030;
  localparam logic [CountW-1:0]  CountMax    = 16'hFFFF;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPORT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic update;  // learn/refresh and age the table from the accepted item
    logic load;    // move the next report into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic rep_last;  // slot under the report pointer is the last one to report
  } sts_t;

endpackage

@@ rtl/dpat_ctrl.sv @@
`timescale 1ns / 1ps

module dpat_ctrl
  import dpat_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_valid_i,
  output logic s_ready_o,
  output logic m_valid_o,
  input  logic m_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Output register may be refilled when empty or being drained
  assign out_free = !out_valid_q || m_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) state_d = ST_REPORT;
      end
      ST_REPORT: begin
        if (out_free && sts_i.rep_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_ready_o  = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.update = s_valid_i;
      end
      ST_REPORT: begin
        cmd_o.load = out_free;
      end
      default: ;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load)     out_valid_d = 1'b1;
    else if (m_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

@@ rtl/dpat_datapath.sv @@
`timescale 1ns / 1ps

module dpat_datapath
  import dpat_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [IdCharW-1:0]  id_char_i,
  input  logic                cfg_we_i,
  input  logic [TtlW-1:0]     cfg_wdata_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic [IdxOutW-1:0]  entry_index_o,
  output logic [DevIdW-1:0]   device_id_o,
  output logic                connected_o,
  output logic [CountW-1:0]   active_count_o,
  output logic                last_o
);

  localparam int IdxW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW  = $clog2(TABLE_ENTRIES + 1);
  localparam int RepN  = (TABLE_ENTRIES < ReportMax) ? TABLE_ENTRIES : ReportMax;

  logic [TtlW-1:0]   ttl_reload_q;
  logic [CntW-1:0]   filled_q;
  logic [DevIdW-1:0] slot_id_q     [TABLE_ENTRIES];
  logic [CountW-1:0] slot_active_q [TABLE_ENTRIES];
  logic [TtlW-1:0]   slot_ttl_q    [TABLE_ENTRIES];
  logic [IdxOutW-1:0] rep_idx_q;

  logic [DevIdW-1:0]        new_id;
  logic [TABLE_ENTRIES-1:0] match;
  logic [TABLE_ENTRIES-1:0] target;
  logic                     any_hit;
  logic                     room;
  logic [TtlW-1:0]          ttl_loaded;
  logic [IdxW-1:0]          rd_idx;
  logic [RepCntW-1:0]       rep_n;
  logic                     rd_conn;

  // Identifier is the raw byte less ASCII zero, 9-bit wrap
  assign new_id = {1'b0, id_char_i} - IdOffset;

  // Parallel compare against the filled slots
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = (CntW'(i) < filled_q) && (slot_id_q[i] == new_id);
    end
  end

  assign any_hit = |match;
  assign room    = filled_q < CntW'(TABLE_ENTRIES);

  // Hit slot, or else the first free slot if there is one
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      target[i] = any_hit ? match[i] : (room && (CntW'(i) == filled_q));
    end
  end

  // Reload then age in the same step, floor at zero
  assign ttl_loaded = (ttl_reload_q == '0) ? '0 : ttl_reload_q - TtlW'(1);

  // Report pointer bookkeeping
  assign rd_idx  = IdxW'(rep_idx_q);
  assign rep_n   = (filled_q >= CntW'(RepN)) ? RepCntW'(RepN) : RepCntW'(filled_q);
  assign rd_conn = slot_ttl_q[rd_idx] != '0;
  assign sts_o.rep_last = ({1'b0, rep_idx_q} + RepCntW'(1)) == rep_n;

  // Configuration register, fill count and report pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_reload_q <= TtlResetVal;
      filled_q     <= '0;
      rep_idx_q    <= '0;
    end else begin
      if (cfg_we_i) ttl_reload_q <= cfg_wdata_i;
      if (cmd_i.update) begin
        rep_idx_q <= '0;
        if (!any_hit && room) filled_q <= filled_q + CntW'(1);
      end else if (cmd_i.load) begin
        rep_idx_q <= rep_idx_q + IdxOutW'(1);
      end
    end
  end

  // Active counts: bump on hit, start at one on insert, clear on disconnect report
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) slot_active_q[i] <= '0;
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (cmd_i.update && target[i]) begin
          if (!any_hit)                           slot_active_q[i] <= CountW'(1);
          else if (slot_active_q[i] != CountMax)  slot_active_q[i] <= slot_active_q[i] + CountW'(1);
        end else if (cmd_i.load && (IdxW'(i) == rd_idx) && !rd_conn) begin
          slot_active_q[i] <= '0;
        end
      end
    end
  end

  // Identifiers and time-to-live, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (target[i]) begin
          slot_ttl_q[i] <= ttl_loaded;
          if (!any_hit) slot_id_q[i] <= new_id;
        end else if ((CntW'(i) < filled_q) && (slot_ttl_q[i] != '0)) begin
          slot_ttl_q[i] <= slot_ttl_q[i] - TtlW'(1);
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      entry_index_o  <= rep_idx_q;
      device_id_o    <= slot_id_q[rd_idx];
      connected_o    <= rd_conn;
      active_count_o <= rd_conn ? slot_active_q[rd_idx] : '0;
      last_o         <= sts_o.rep_last;
    end
  end

endmodule

@@ rtl/device_presence_aging_table.sv @@
`timescale 1ns / 1ps

// Device presence table. Each item on the slave stream is one identifier
// byte; the stored identifier is the byte less 0x30. A known identifier
// gets its active count bumped (saturating) and its time-to-live reloaded
// from the ttl register; an unknown one takes the next free slot, or is
// dropped once all TABLE_ENTRIES slots are filled. All filled slots then
// age by one, and the first min(filled, 16) slots are reported in order,
// tlast on the final one; a disconnected slot reports count zero and has
// its count cleared. An item is handled as an update step (parallel compare
// over all slots) and then its reports; no new item is taken until the
// last report is loaded. Configuration takes effect on the next item;
// write it only while the block is idle.
module device_presence_aging_table
  import dpat_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave stream: tdata[7:0] id_char
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [IdCharW-1:0]  s_axis_tdata,
  // master stream: tdata[3:0] entry_index, [12:4] device_id,
  // [13] connected, [29:14] active_count, [31:30] zero
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,
  // ttl_reload register
  input  logic                cfg_we_i,
  input  logic [TtlW-1:0]     cfg_wdata_i
);

  cmd_t               cmd;
  sts_t               sts;
  logic [IdxOutW-1:0] entry_index;
  logic [DevIdW-1:0]  device_id;
  logic               connected;
  logic [CountW-1:0]  active_count;

  dpat_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dpat_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .id_char_i      (s_axis_tdata),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .entry_index_o  (entry_index),
    .device_id_o    (device_id),
    .connected_o    (connected),
    .active_count_o (active_count),
    .last_o         (m_axis_tlast)
  );

  // Pack result fields, lowest field first
  assign m_axis_tdata = {2'b00, active_count, connected, device_id, entry_index};

endmodule

@@ test/presence_report_checker.sv @@
`timescale 1ns / 1ps

// Watches both streams and the ttl register port, keeps its own copy of the
// presence table and compares every slot report with the predicted one.
module presence_report_checker
  import dpat_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [IdCharW-1:0]  s_tdata_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic                m_tlast_i,
  input  logic                cfg_we_i,
  input  logic [TtlW-1:0]     cfg_wdata_i,
  output int                  mismatch_count_o,
  output int                  reports_pending_o
);

  localparam int Slots     = TableEntriesDef;
  localparam int ReportLog = 10;

  typedef struct packed {
    logic [IdxOutW-1:0] entry_index;
    logic [DevIdW-1:0]  device_id;
    logic               connected;
    logic [CountW-1:0]  active_count;
    logic               last;
  } report_t;

  // Shadow table
  logic              slot_used [Slots];
  logic [DevIdW-1:0] slot_dev  [Slots];
  logic [CountW-1:0] slot_cnt  [Slots];
  logic [TtlW-1:0]   slot_life [Slots];
  int                used_n;
  logic [TtlW-1:0]   ttl_reload;

  report_t           report_q [$];
  int                mismatch_n = 0;

  assign mismatch_count_o = mismatch_n;

  // Learn or refresh one identifier, age the table, queue the slot reports
  task automatic hear_device(input logic [IdCharW-1:0] id_char);
    logic [DevIdW-1:0] dev;
    logic              placed;
    int                n_rep;
    report_t           rep;
    dev    = {1'b0, id_char} - IdOffset;
    placed = 1'b0;
    for (int i = 0; i < Slots; i++) begin
      if (!placed) begin
        if (!slot_used[i]) begin
          slot_used[i] = 1'b1;
          slot_dev[i]  = dev;
          slot_cnt[i]  = CountW'(1);
          slot_life[i] = ttl_reload;
          used_n++;
          placed = 1'b1;
        end else if (slot_dev[i] == dev) begin
          if (slot_cnt[i] != CountMax) slot_cnt[i] = slot_cnt[i] + 1'b1;
          slot_life[i] = ttl_reload;
          placed = 1'b1;
        end
      end
    end
    // aging, floor at zero
    for (int i = 0; i < Slots; i++) begin
      if (slot_used[i] && slot_life[i] != 0) slot_life[i] = slot_life[i] - 1'b1;
    end
    n_rep = (used_n > ReportMax) ? ReportMax : used_n;
    for (int i = 0; i < n_rep; i++) begin
      // expired slot drops its count
      if (slot_life[i] == 0) slot_cnt[i] = '0;
      rep.entry_index  = IdxOutW'(i);
      rep.device_id    = slot_dev[i];
      rep.connected    = (slot_life[i] != 0);
      rep.active_count = slot_cnt[i];
      rep.last         = (i == n_rep - 1);
      report_q.push_back(rep);
    end
  endtask

  // Compare one accepted report with the oldest prediction
  task automatic check_report();
    report_t    want;
    report_t    seen;
    logic [1:0] pad;
    seen = {m_tdata_i[3:0], m_tdata_i[12:4], m_tdata_i[13], m_tdata_i[29:14], m_tlast_i};
    pad  = m_tdata_i[31:30];
    if (report_q.size() == 0) begin
      mismatch_n++;
      if (mismatch_n <= ReportLog)
        $display("%0t: unexpected report slot %0d id %0d conn %0b cnt %0d last %0b",
                 $realtime, seen.entry_index, $signed(seen.device_id), seen.connected,
                 seen.active_count, seen.last);
    end else begin
      want = report_q.pop_front();
      if (seen !== want || pad !== 2'b00) begin
        mismatch_n++;
        if (mismatch_n <= ReportLog) begin
          $display("%0t: report mismatch", $realtime);
          $display("  exp slot %0d id %0d conn %0b cnt %0d last %0b pad 0",
                   want.entry_index, $signed(want.device_id), want.connected,
                   want.active_count, want.last);
          $display("  got slot %0d id %0d conn %0b cnt %0d last %0b pad %0d",
                   seen.entry_index, $signed(seen.device_id), seen.connected,
                   seen.active_count, seen.last, pad);
        end
      end
    end
  endtask

  // Sample both streams and the register port at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        slot_used[i] = 1'b0;
        slot_dev[i]  = '0;
        slot_cnt[i]  = '0;
        slot_life[i] = '0;
      end
      used_n     = 0;
      ttl_reload = TtlResetVal;
      report_q.delete();
    end else begin
      if (cfg_we_i) ttl_reload = cfg_wdata_i;
      if (m_tvalid_i && m_tready_i) check_report();
      if (s_tvalid_i && s_tready_i) hear_device(s_tdata_i);
    end
    reports_pending_o <= report_q.size();
  end

endmodule

@@ test/device_presence_aging_table_test.sv @@
`timescale 1ns / 1ps

module device_presence_aging_table_test;
  import dpat_pkg::*;

  localparam int ResetCycles = 12;
  localparam int SoakItems   = 24;  // repeated hits on one slot
  localparam int PhaseItems  = 52;
  localparam int Phases      = 5;
  localparam int HoldCycles  = 400;
  localparam int IdleLimit   = 4000;
  localparam int DrainCycles = 40;
  localparam logic [IdCharW-1:0] HomeChar = 8'h30;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_HALF,
    RX_SPARSE,
    RX_TOGGLE
  } rx_mode_e;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IdCharW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_we        = 1'b0;
  logic [TtlW-1:0]     cfg_wdata     = '0;

  int                  mismatches;
  int                  pending;
  int                  burst_left    = 0;
  bit                  hold_req      = 1'b0;
  logic [IdCharW-1:0]  known_q [$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  device_presence_aging_table uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  presence_report_checker checker_i (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .s_tvalid_i        (s_axis_tvalid),
    .s_tready_i        (s_axis_tready),
    .s_tdata_i         (s_axis_tdata),
    .m_tvalid_i        (m_axis_tvalid),
    .m_tready_i        (m_axis_tready),
    .m_tdata_i         (m_axis_tdata),
    .m_tlast_i         (m_axis_tlast),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .mismatch_count_o  (mismatches),
    .reports_pending_o (pending)
  );

  // Offer one identifier byte; bursts of random length with random gaps
  task automatic send_id(input logic [IdCharW-1:0] id_char);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= id_char;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
  endtask

  // Send and remember which bytes should now sit in the table
  task automatic hear(input logic [IdCharW-1:0] id_char);
    logic seen;
    seen = 1'b0;
    send_id(id_char);
    foreach (known_q[k]) if (known_q[k] == id_char) seen = 1'b1;
    if (!seen && known_q.size() < TableEntriesDef) known_q.push_back(id_char);
  endtask

  // Let all reports drain, then write the ttl register
  task automatic set_ttl(input logic [TtlW-1:0] ttl);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ttl;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Hits on a hot window of stored ids most often, some on any stored id, rest noise
  function automatic logic [IdCharW-1:0] pick_char(input int hot_base);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return known_q[(hot_base + $urandom_range(0, 3)) % known_q.size()];
    else if (roll < 75) return known_q[$urandom_range(0, known_q.size() - 1)];
    else return IdCharW'($urandom_range(0, 255));
  endfunction

  // Receiver: segments of differing ready patterns, one long hold-off on request
  initial begin
    rx_mode_e mode;
    int       seg;
    logic     rdy;
    wait (rst_n === 1'b1);
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      seg  = $urandom_range(8, 80);
      repeat (seg) begin
        @(posedge clk);
        case (mode)
          RX_OPEN:   rdy = 1'b1;
          RX_HALF:   rdy = 1'($urandom_range(0, 1));
          RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
          default:   rdy = ~m_axis_tready;
        endcase
        m_axis_tready <= rdy;
      end
      if (hold_req) begin
        hold_req = 1'b0;
        @(posedge clk);
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
    end
  end

  // Watchdog: too long without any item moving on either stream
  initial begin
    int idle_n;
    idle_n = 0;
    while (idle_n < IdleLimit) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_n = 0;
      else idle_n++;
    end
    $display("Verification failed");
    $finish;
  end

  // Stimulus
  initial begin
    int hot_base;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one slot hit over and over at the reset ttl: count climbs
    repeat (SoakItems) hear(HomeChar);

    // extremes, identifier -1 and walking bits fill the table
    hear(8'h00); hear(8'hFF); hear(8'h2F); hear(8'h80); hear(8'h7F);
    hear(8'h01); hear(8'h02); hear(8'h04); hear(8'h08);
    hear(8'h10); hear(8'h20); hear(8'h40);
    hear(8'h31); hear(8'h32); hear(8'h33);
    // table full: unknown id dropped, known id still hits
    hear(8'h99);
    hear(8'hFF);

    // zero reload: disconnected in the same item
    set_ttl(4'd0);
    hear(8'h2F); hear(8'h2F);
    // expired home slot restarts its count
    set_ttl(4'd15);
    hear(8'h00); hear(HomeChar);
    // reload of one, everything else sits at the floor
    set_ttl(4'd1);
    hear(8'h7F); hear(8'h7F);

    // random phases over several ttl settings
    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0:       set_ttl(4'd15);
        1:       set_ttl(4'd1);
        2:       set_ttl(4'd0);
        3:       set_ttl(TtlW'($urandom_range(2, 14)));
        default: set_ttl(TtlResetVal);
      endcase
      // long receiver hold-off while items keep coming
      if (ph == 0) hold_req = 1'b1;
      hot_base = $urandom_range(0, TableEntriesDef - 1);
      repeat (PhaseItems) hear(pick_char(hot_base));
    end

    // drain and let any stray report show up
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ device_presence_aging_table.f @@
rtl/dpat_pkg.sv
rtl/dpat_ctrl.sv
rtl/dpat_datapath.sv
rtl/device_presence_aging_table.sv
test/presence_report_checker.sv
test/device_presence_aging_table_test.sv
